### design/fpr_pkg.sv
package fpr_pkg;

    localparam int PHASE_W = 3;
    localparam int STATUS_W = 3;
    localparam int REG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PH_START   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM   = 3'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic RK_PAYLOAD = 1'b0;
    localparam logic RK_STATUS  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_START_MARKER  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_TIMEOUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BYTE_TIMEOUT  = 2'd2;

    localparam logic [7:0]  RST_START_MARKER  = 8'hAA;
    localparam logic [15:0] RST_START_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_BYTE_TIMEOUT  = 16'd1000;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [15:0] start_timeout;
        logic [15:0] byte_timeout;
    } t_cfg;

    typedef struct packed {
        logic                result_kind;
        logic [6:0]          byte_index;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] status;
        logic [15:0]         frame_length;
    } t_result;

endpackage

### design/fpr_regs.sv
module fpr_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fpr_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fpr_pkg::t_cfg                 o_cfg
);
    import fpr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_START_MARKER:  n_cfg.start_marker  = i_cfg_data[7:0];
                REG_START_TIMEOUT: n_cfg.start_timeout = i_cfg_data;
                REG_BYTE_TIMEOUT:  n_cfg.byte_timeout  = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker  <= RST_START_MARKER;
            r_cfg.start_timeout <= RST_START_TIMEOUT;
            r_cfg.byte_timeout  <= RST_BYTE_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/fpr_core.sv
module fpr_core #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_rx_byte,
    input  fpr_pkg::t_cfg     i_cfg,
    output logic              o_res_valid,
    output fpr_pkg::t_result  o_res
);
    import fpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [15:0]        r_ticks, n_ticks;
    logic [15:0]        r_len, n_len;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_xor, n_xor;

    logic [15:0] count_ext;
    logic [15:0] count_inc;
    logic [15:0] len_full;
    logic        end_sess;
    logic [STATUS_W-1:0] end_status;
    logic        pay_out;

    assign count_ext = 16'(r_count);
    assign count_inc = count_ext + 16'd1;
    assign len_full  = {i_rx_byte, r_len[7:0]};

    always_comb begin
        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_len      = r_len;
        n_count    = r_count;
        n_xor      = r_xor;
        end_sess   = 1'b0;
        end_status = ST_OK;
        pay_out    = 1'b0;
        o_res      = '0;

        if (i_kind == KIND_TICK) begin
            if (r_ticks == 16'd0) begin
                end_sess   = 1'b1;
                end_status = ST_TIMEOUT;
            end else begin
                n_ticks = r_ticks - 16'd1;
            end
        end else begin
            case (r_phase)
                PH_LEN_LO: begin
                    n_len   = {8'd0, i_rx_byte};
                    n_ticks = i_cfg.byte_timeout;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = len_full;
                    if (len_full == 16'd0 || len_full > MAX_LEN) begin
                        end_sess   = 1'b1;
                        end_status = ST_BAD_LENGTH;
                    end else begin
                        n_ticks = i_cfg.byte_timeout;
                        n_count = '0;
                        n_xor   = 8'd0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    pay_out = 1'b1;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = CNT_W'(count_inc);
                    n_ticks = i_cfg.byte_timeout;
                    if (count_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    end_sess   = 1'b1;
                    end_status = (r_xor == i_rx_byte) ? ST_OK : ST_CHECKSUM;
                end
                default: begin
                    if (i_rx_byte != i_cfg.start_marker) begin
                        end_sess   = 1'b1;
                        end_status = ST_BAD_START;
                    end else begin
                        n_len   = 16'd0;
                        n_count = '0;
                        n_xor   = 8'd0;
                        n_ticks = i_cfg.byte_timeout;
                        n_phase = PH_LEN_LO;
                    end
                end
            endcase
        end

        if (end_sess) begin
            o_res.result_kind  = RK_STATUS;
            o_res.status       = end_status;
            o_res.frame_length = n_len;
            n_phase = PH_START;
            n_ticks = i_cfg.start_timeout;
            n_len   = 16'd0;
            n_count = '0;
            n_xor   = 8'd0;
        end else if (pay_out) begin
            o_res.result_kind  = RK_PAYLOAD;
            o_res.byte_index   = count_ext[6:0];
            o_res.payload_byte = i_rx_byte;
        end
    end

    assign o_res_valid = end_sess | pay_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_ticks <= RST_START_TIMEOUT;
            r_len   <= 16'd0;
            r_count <= '0;
            r_xor   <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_len   <= n_len;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

endmodule

### design/fpr_skid.sv
module fpr_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fpr_pkg::t_result i_data,
    output logic             o_can_accept,
    output logic             o_valid,
    input  logic             i_ready,
    output fpr_pkg::t_result o_data
);
    import fpr_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_can_accept = ~r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out;

endmodule

### design/framed_payload_receiver_top.sv
// Results are registered: each goes to the output register, or to the skid register while that one is held.
// Throughput: one input transaction per cycle while o_ready is high; the frame state updates in a single pass.
// A two-entry output buffer keeps input flowing while one result waits downstream.
// Reset (synchronous, active low) restores the register defaults, clears the frame
// state, empties the output buffer and arms the start-byte timeout.
module framed_payload_receiver_top #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [fpr_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_result_kind,
    output logic [6:0]                     o_byte_index,
    output logic [7:0]                     o_payload_byte,
    output logic [fpr_pkg::STATUS_W-1:0]   o_status,
    output logic [15:0]                    o_frame_length
);
    import fpr_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    core_res_valid;
    logic    accept;

    assign accept = i_valid & o_ready;

    fpr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fpr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    fpr_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept & core_res_valid),
        .i_data       (core_res),
        .o_can_accept (o_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (out_res)
    );

    assign o_result_kind  = out_res.result_kind;
    assign o_byte_index   = out_res.byte_index;
    assign o_payload_byte = out_res.payload_byte;
    assign o_status       = out_res.status;
    assign o_frame_length = out_res.frame_length;

endmodule
